### rtl/core/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, codes and constants of the timed step sequencer.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int STEP_DEPTH_DEF = 16;   // default table depth
  localparam int MAX_RESULTS    = 16;   // steps applied per tick at most
  localparam int TICK_MS        = 10;   // one tick is 10 ms

  // Field widths
  localparam int REQ_W   = 3;
  localparam int SEC_W   = 32;
  localparam int SYNC_W  = 2;
  localparam int IDX_W   = 4;
  localparam int OFF_W   = 20;
  localparam int VAL_W   = 16;
  localparam int VALS_W  = 4 * VAL_W;
  localparam int TGT_W   = 16;
  localparam int TICK_W  = 32;
  localparam int SCNT_W  = 5;
  localparam int CFG_A_W = 1;
  localparam int CFG_D_W = 32;
  localparam int RCNT_W  = $clog2(MAX_RESULTS + 1);

  // Offset in ms to ticks: x / 10 == (x * DIV10_MUL) >> DIV10_SH, exact over 20 bits
  localparam int DIV10_SH  = 23;
  localparam int DIV10_MUL = ((1 << DIV10_SH) + TICK_MS - 1) / TICK_MS;
  localparam int PROD_W    = OFF_W + DIV10_SH;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_START_TIME = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_STEP_COUNT = 1'd1;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CONFIG = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd4;

  // Time sync status
  localparam logic [SYNC_W-1:0] SYNC_OK     = 2'd1;
  localparam logic [SYNC_W-1:0] SYNC_FAILED = 2'd2;

  typedef enum logic [2:0] {
    MODE_UNCONF     = 3'd0,
    MODE_CONFIGURING = 3'd1,
    MODE_AWAIT_START = 3'd2,
    MODE_AWAIT_TIME  = 3'd3,
    MODE_RUNNING     = 3'd4,
    MODE_SUCCESS     = 3'd5,
    MODE_STOPPED     = 3'd6,
    MODE_CFG_ERROR   = 3'd7
  } mode_t;

  // Table write: target ticks and the four line values
  typedef struct packed {
    logic              en;
    logic [TGT_W-1:0]  tgt;
    logic [VALS_W-1:0] vals;
  } tss_wr_t;

  // One result item
  typedef struct packed {
    mode_t             mode;
    logic              applied;
    logic [VALS_W-1:0] vals;
    logic [TICK_W-1:0] elapsed;
    logic              sync_error;
    logic              last;
  } tss_res_t;

endpackage

### rtl/core/tss_table.sv
// ----------------------------------------------------------------------------
// tss_table
// Step table: target-tick memory and line-value memory, one write port,
// one registered read port each.
// ----------------------------------------------------------------------------
module tss_table import tss_pkg::*; #(
  parameter int STEP_DEPTH = STEP_DEPTH_DEF,
  parameter int AW         = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1
) (
  input  logic              clk,
  input  tss_wr_t           wr,
  input  logic [AW-1:0]     wr_addr,
  input  logic              tgt_rd_en,
  input  logic [AW-1:0]     tgt_rd_addr,
  output logic [TGT_W-1:0]  tgt_rdata,
  input  logic              val_rd_en,
  input  logic [AW-1:0]     val_rd_addr,
  output logic [VALS_W-1:0] val_rdata
);

  logic [TGT_W-1:0]  tgt_mem [STEP_DEPTH];
  logic [VALS_W-1:0] val_mem [STEP_DEPTH];
  logic [TGT_W-1:0]  tgt_rdata_r;
  logic [VALS_W-1:0] val_rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      tgt_mem[wr_addr] <= wr.tgt;
      val_mem[wr_addr] <= wr.vals;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (tgt_rd_en) begin
      tgt_rdata_r <= tgt_mem[tgt_rd_addr];
    end
    if (val_rd_en) begin
      val_rdata_r <= val_mem[val_rd_addr];
    end
  end

  assign tgt_rdata = tgt_rdata_r;
  assign val_rdata = val_rdata_r;

endmodule

### rtl/core/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Command decode, mode machine and step walk. A tick first walks the due
// steps through the target memory, then replays the applied range through
// the value memory so every result carries the final mode.
// ----------------------------------------------------------------------------
module tss_ctrl import tss_pkg::*; #(
  parameter int STEP_DEPTH = STEP_DEPTH_DEF,
  parameter int AW         = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [SEC_W-1:0]   now_seconds,
  input  logic [SYNC_W-1:0]  sync_status,
  input  logic [IDX_W-1:0]   step_index,
  input  logic [OFF_W-1:0]   step_offset_ms,
  input  logic [VALS_W-1:0]  step_vals,
  output tss_wr_t            wr,
  output logic [AW-1:0]      wr_addr,
  output logic               tgt_rd_en,
  output logic [AW-1:0]      tgt_rd_addr,
  input  logic [TGT_W-1:0]   tgt_rdata,
  output logic               val_rd_en,
  output logic [AW-1:0]      val_rd_addr,
  input  logic [VALS_W-1:0]  val_rdata,
  output logic               res_valid,
  output tss_res_t           res,
  input  logic               res_ready
);

  localparam int CS_W  = AW + 1;
  localparam int LIM_W = (CS_W > SCNT_W) ? CS_W : SCNT_W;
  localparam logic [CS_W-1:0] STEP_NONE = '1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_WALK = 7'b0000100,
    S_TGT  = 7'b0001000,
    S_STAT = 7'b0010000,
    S_VRD  = 7'b0100000,
    S_VOUT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [CS_W-1:0]     cur_r, cur_nxt;
  logic                waiting_r, waiting_nxt;
  logic [TGT_W-1:0]    target_r, target_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic                counting_r, counting_nxt;
  logic                serr_r, serr_nxt;
  logic [SEC_W-1:0]    start_time_r, start_time_nxt;
  logic [SCNT_W-1:0]   step_count_r, step_count_nxt;
  logic [RCNT_W-1:0]   n_r, n_nxt;
  logic [CS_W-1:0]     emit_idx_r, emit_idx_nxt;

  // Latched item
  logic [REQ_W-1:0]    req_r;
  logic [SEC_W-1:0]    now_r;
  logic [SYNC_W-1:0]   sync_r;
  logic [IDX_W-1:0]    idx_r;
  logic [OFF_W-1:0]    off_r;
  logic [VALS_W-1:0]   vals_r;

  logic [PROD_W-1:0]   div_prod;
  logic [CS_W-1:0]     cur_inc;
  logic [LIM_W-1:0]    limit;
  logic                walk_done;

  assign div_prod = PROD_W'(off_r) * PROD_W'(DIV10_MUL);
  assign cur_inc  = cur_r + 1'b1;
  assign limit    = (LIM_W'(step_count_r) > LIM_W'(STEP_DEPTH)) ?
                    LIM_W'(STEP_DEPTH) : LIM_W'(step_count_r);

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r  <= req_type;
      now_r  <= now_seconds;
      sync_r <= sync_status;
      idx_r  <= step_index;
      off_r  <= step_offset_ms;
      vals_r <= step_vals;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cur_nxt        = cur_r;
    waiting_nxt    = waiting_r;
    target_nxt     = target_r;
    tick_nxt       = tick_r;
    counting_nxt   = counting_r;
    serr_nxt       = serr_r;
    start_time_nxt = start_time_r;
    step_count_nxt = step_count_r;
    n_nxt          = n_r;
    emit_idx_nxt   = emit_idx_r;
    walk_done      = 1'b0;

    in_ready    = (state_r == S_IDLE);
    wr.en       = 1'b0;
    wr.tgt      = div_prod[DIV10_SH +: TGT_W];
    wr.vals     = vals_r;
    wr_addr     = AW'(idx_r);
    tgt_rd_en   = 1'b0;
    tgt_rd_addr = cur_inc[AW-1:0];
    val_rd_en   = 1'b0;
    val_rd_addr = emit_idx_r[AW-1:0];
    res_valid   = 1'b0;
    res.mode       = mode_r;
    res.applied    = 1'b0;
    res.vals       = '0;
    res.elapsed    = tick_r;
    res.sync_error = serr_r;
    res.last       = 1'b1;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_START_TIME: start_time_nxt = cfg_wdata;
        CFG_STEP_COUNT: step_count_nxt = cfg_wdata[SCNT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_STAT;
        case (req_r)
          REQ_TICK: begin
            if (counting_r) begin
              tick_nxt = tick_r + 1'b1;
            end
            if (mode_r == MODE_CONFIGURING) begin
              if (sync_r == SYNC_OK) begin
                mode_nxt = MODE_AWAIT_START;
              end else if (sync_r == SYNC_FAILED) begin
                mode_nxt = MODE_CFG_ERROR;
                serr_nxt = 1'b1;
              end
            end else if (mode_r == MODE_AWAIT_TIME && now_r >= start_time_r) begin
              mode_nxt     = MODE_RUNNING;
              tick_nxt     = '0;
              counting_nxt = 1'b1;
              cur_nxt      = STEP_NONE;
              waiting_nxt  = 1'b0;
            end
            n_nxt     = '0;
            state_nxt = S_WALK;
          end
          REQ_LOAD: begin
            wr.en = (int'(idx_r) < STEP_DEPTH);
          end
          REQ_CONFIG: mode_nxt = MODE_CONFIGURING;
          REQ_START:  mode_nxt = MODE_AWAIT_TIME;
          REQ_STOP: begin
            counting_nxt = 1'b0;
            mode_nxt     = MODE_STOPPED;
          end
          default: ;
        endcase
      end

      S_WALK: begin
        if (mode_r != MODE_RUNNING) begin
          walk_done = 1'b1;
        end else if (waiting_r) begin
          if (tick_r < TICK_W'(target_r) || n_r >= RCNT_W'(MAX_RESULTS)) begin
            walk_done = 1'b1;
          end else begin
            // record the applied step; applied steps form one consecutive run
            if (n_r == '0) begin
              emit_idx_nxt = cur_r;
            end
            n_nxt       = n_r + 1'b1;
            waiting_nxt = 1'b0;
          end
        end else begin
          cur_nxt = cur_inc;
          if (LIM_W'(cur_inc) < limit) begin
            tgt_rd_en = 1'b1;
            state_nxt = S_TGT;
          end else begin
            mode_nxt     = MODE_SUCCESS;
            counting_nxt = 1'b0;
          end
        end
        if (walk_done) begin
          state_nxt = (n_r == '0) ? S_STAT : S_VRD;
        end
      end

      S_TGT: begin
        target_nxt  = tgt_rdata;
        waiting_nxt = 1'b1;
        state_nxt   = S_WALK;
      end

      S_STAT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_VRD: begin
        val_rd_en = 1'b1;
        state_nxt = S_VOUT;
      end

      S_VOUT: begin
        res_valid   = 1'b1;
        res.applied = 1'b1;
        res.vals    = val_rdata;
        res.last    = (n_r == RCNT_W'(1));
        if (res_ready) begin
          emit_idx_nxt = emit_idx_r + 1'b1;
          n_nxt        = n_r - 1'b1;
          state_nxt    = (n_r == RCNT_W'(1)) ? S_IDLE : S_VRD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_UNCONF;
      cur_r        <= STEP_NONE;
      waiting_r    <= 1'b0;
      target_r     <= '0;
      tick_r       <= '0;
      counting_r   <= 1'b0;
      serr_r       <= 1'b0;
      start_time_r <= '0;
      step_count_r <= '0;
      n_r          <= '0;
      emit_idx_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      cur_r        <= cur_nxt;
      waiting_r    <= waiting_nxt;
      target_r     <= target_nxt;
      tick_r       <= tick_nxt;
      counting_r   <= counting_nxt;
      serr_r       <= serr_nxt;
      start_time_r <= start_time_nxt;
      step_count_r <= step_count_nxt;
      n_r          <= n_nxt;
      emit_idx_r   <= emit_idx_nxt;
    end
  end

endmodule

### rtl/core/timed_step_sequencer.sv
// ----------------------------------------------------------------------------
// timed_step_sequencer
// Timed playback of a table of line-condition steps, streaming in and out.
// ----------------------------------------------------------------------------
// A command's status result enters the output register from S_STAT once the
// accepted item has passed S_EXEC; a tick applying no step also passes S_WALK.
// A tick walks S_WALK and S_TGT for each step looked up, then S_VRD and S_VOUT
// for each applied step; S_STAT and S_VOUT wait for the output register.
// One item at a time; the next is accepted the cycle after its last result is taken into the output register.
// Reset (synchronous, rst_n low): mode unconfigured, no step current, counters,
// flags and output valid cleared; table contents stay undefined until loaded.
module timed_step_sequencer import tss_pkg::*; #(
  parameter int STEP_DEPTH = STEP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_D_W-1:0] cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  // now_seconds, sync_status, step_index, step_offset_ms, breakage_value,
  // impedance_value, attenuation_value, resistance_value, zero fill
  input  logic [127:0]       in_tdata,
  // req_type
  input  logic [2:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // mode, applied, out_breakage, out_impedance, out_attenuation,
  // out_resistance, elapsed_ticks, sync_error, zero fill
  output logic [103:0]       out_tdata,
  output logic               out_tlast
);

  localparam int AW = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;

  tss_wr_t            wr;
  logic [AW-1:0]      wr_addr;
  logic               tgt_rd_en;
  logic [AW-1:0]      tgt_rd_addr;
  logic [TGT_W-1:0]   tgt_rdata;
  logic               val_rd_en;
  logic [AW-1:0]      val_rd_addr;
  logic [VALS_W-1:0]  val_rdata;
  logic               res_valid;
  logic               res_ready;
  tss_res_t           res;

  logic               out_valid_r;
  logic [103:0]       out_data_r;
  logic               out_last_r;

  tss_ctrl #(
    .STEP_DEPTH (STEP_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .req_type       (in_tuser),
    .now_seconds    (in_tdata[31:0]),
    .sync_status    (in_tdata[33:32]),
    .step_index     (in_tdata[37:34]),
    .step_offset_ms (in_tdata[57:38]),
    .step_vals      (in_tdata[121:58]),
    .wr             (wr),
    .wr_addr        (wr_addr),
    .tgt_rd_en      (tgt_rd_en),
    .tgt_rd_addr    (tgt_rd_addr),
    .tgt_rdata      (tgt_rdata),
    .val_rd_en      (val_rd_en),
    .val_rd_addr    (val_rd_addr),
    .val_rdata      (val_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  tss_table #(
    .STEP_DEPTH (STEP_DEPTH),
    .AW         (AW)
  ) u_table (
    .clk         (clk),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .tgt_rd_en   (tgt_rd_en),
    .tgt_rd_addr (tgt_rd_addr),
    .tgt_rdata   (tgt_rdata),
    .val_rd_en   (val_rd_en),
    .val_rd_addr (val_rd_addr),
    .val_rdata   (val_rdata)
  );

  // Output register: refill whenever it is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= {3'b000, res.sync_error, res.elapsed, res.vals,
                     res.applied, res.mode};
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

### tb/tb_timed_step_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_step_sequencer
// Self-checking bench for the timed step sequencer. Fills the step table and
// runs short directed command sequences, then random playback runs (configure,
// sync, start, tick until done) mixed with noise. A scoreboard predicts every
// result item from its own copy of the sequencer state and compares each
// result field by field, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_timed_step_sequencer;
  import tss_pkg::*;

  localparam int RAND_ITEMS = 230;
  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_ITEMS = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS = 100;
  localparam logic [SYNC_W-1:0] SYNC_BUSY = 2'd0;
  localparam logic [SYNC_W-1:0] SYNC_UNDEF = 2'd3;
  localparam logic [REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_LAST = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]  req;
    logic [SEC_W-1:0]  now;
    logic [SYNC_W-1:0] sync;
    logic [IDX_W-1:0]  idx;
    logic [OFF_W-1:0]  off;
    logic [VAL_W-1:0]  brk;
    logic [VAL_W-1:0]  imp;
    logic [VAL_W-1:0]  att;
    logic [VAL_W-1:0]  res;
  } step_req_t;

  class playback_scoreboard;
    logic [SEC_W-1:0]  start_time;
    logic [SCNT_W-1:0] step_count;
    mode_t             mode;
    logic [OFF_W-1:0]  offsets[STEP_DEPTH_DEF];
    logic [VALS_W-1:0] line_vals[STEP_DEPTH_DEF];
    logic [4:0]        cur_step;
    logic              waiting;
    logic [TGT_W-1:0]  target;
    logic [TICK_W-1:0] ticks;
    logic              counting;
    logic              sync_err;
    tss_res_t          expected[$];
    int                errors;

    function new();
      start_time = '0;
      step_count = '0;
      mode = MODE_UNCONF;
      cur_step = 5'h1f;
      waiting = 1'b0;
      target = '0;
      ticks = '0;
      counting = 1'b0;
      sync_err = 1'b0;
      errors = 0;
      foreach (offsets[i]) begin
        offsets[i] = '0;
        line_vals[i] = '0;
      end
    endfunction

    function void set_reg(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] data);
      if (addr == CFG_START_TIME) start_time = data;
      else step_count = data[SCNT_W-1:0];
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Update the sequencer state for one accepted item and queue its results.
    function void note_item(step_req_t it);
      logic [VALS_W-1:0] applied_vals[$];
      int lim;
      tss_res_t r;
      case (it.req)
        REQ_TICK: begin
          if (counting) ticks = ticks + 1;
          if (mode == MODE_CONFIGURING) begin
            if (it.sync == SYNC_OK) begin
              mode = MODE_AWAIT_START;
            end else if (it.sync == SYNC_FAILED) begin
              mode = MODE_CFG_ERROR;
              sync_err = 1'b1;
            end
          end else if (mode == MODE_AWAIT_TIME && it.now >= start_time) begin
            mode = MODE_RUNNING;
            ticks = '0;
            counting = 1'b1;
            cur_step = 5'h1f;
            waiting = 1'b0;
          end
          lim = (step_count < STEP_DEPTH_DEF) ? step_count : STEP_DEPTH_DEF;
          // walk due steps until one is not yet due, the per-tick limit is reached or the table is done
          while (mode == MODE_RUNNING) begin
            if (waiting) begin
              if (ticks < target || applied_vals.size() >= MAX_RESULTS) break;
              applied_vals.push_back(line_vals[cur_step[3:0]]);
              waiting = 1'b0;
            end else begin
              cur_step = cur_step + 5'd1;
              if (cur_step < lim) begin
                target = TGT_W'(offsets[cur_step[3:0]] / TICK_MS);
                waiting = 1'b1;
              end else begin
                mode = MODE_SUCCESS;
                counting = 1'b0;
              end
            end
          end
        end
        REQ_LOAD: begin
          offsets[it.idx] = it.off;
          line_vals[it.idx] = {it.res, it.att, it.imp, it.brk};
        end
        REQ_CONFIG: mode = MODE_CONFIGURING;
        REQ_START: mode = MODE_AWAIT_TIME;
        REQ_STOP: begin
          counting = 1'b0;
          mode = MODE_STOPPED;
        end
        default: ;
      endcase
      r.mode = mode;
      r.elapsed = ticks;
      r.sync_error = sync_err;
      if (applied_vals.size() == 0) begin
        r.applied = 1'b0;
        r.vals = '0;
        r.last = 1'b1;
        expected.push_back(r);
      end else begin
        foreach (applied_vals[k]) begin
          r.applied = 1'b1;
          r.vals = applied_vals[k];
          r.last = (k == applied_vals.size() - 1);
          expected.push_back(r);
        end
      end
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    task check_result(tss_res_t got);
      tss_res_t want;
      if (expected.size() == 0) begin
        report("result with nothing pending, mode", got.mode, 0);
        return;
      end
      want = expected.pop_front();
      if (got.mode !== want.mode) report("mode", got.mode, want.mode);
      if (got.applied !== want.applied) report("applied", got.applied, want.applied);
      if (got.vals[15:0] !== want.vals[15:0])
        report("breakage", got.vals[15:0], want.vals[15:0]);
      if (got.vals[31:16] !== want.vals[31:16])
        report("impedance", got.vals[31:16], want.vals[31:16]);
      if (got.vals[47:32] !== want.vals[47:32])
        report("attenuation", got.vals[47:32], want.vals[47:32]);
      if (got.vals[63:48] !== want.vals[63:48])
        report("resistance", got.vals[63:48], want.vals[63:48]);
      if (got.elapsed !== want.elapsed) report("elapsed_ticks", got.elapsed, want.elapsed);
      if (got.sync_error !== want.sync_error)
        report("sync_error", got.sync_error, want.sync_error);
      if (got.last !== want.last) report("last", got.last, want.last);
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CFG_A_W-1:0] cfg_addr;
  logic [CFG_D_W-1:0] cfg_wdata;
  logic               in_tvalid;
  logic               in_tready;
  logic [127:0]       in_tdata;
  logic [2:0]         in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [103:0]       out_tdata;
  logic               out_tlast;

  playback_scoreboard sb;
  int rand_items;
  bit calm;
  bit hold_req;

  timed_step_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic step_req_t rand_item(logic [REQ_W-1:0] req);
    step_req_t it;
    it.req = req;
    it.now = $urandom;
    it.sync = SYNC_W'($urandom_range(0, 3));
    it.idx = IDX_W'($urandom_range(0, STEP_DEPTH_DEF - 1));
    it.off = OFF_W'($urandom);
    it.brk = VAL_W'($urandom);
    it.imp = VAL_W'($urandom);
    it.att = VAL_W'($urandom);
    it.res = VAL_W'($urandom);
    return it;
  endfunction

  task automatic send_item(step_req_t it);
    in_tuser <= it.req;
    in_tdata <= {6'd0, it.res, it.att, it.imp, it.brk, it.off, it.idx, it.sync, it.now};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(it);
    if (rand_items >= 0) rand_items++;
    calm = (rand_items >= RAND_ITEMS - CALM_ITEMS);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(logic [REQ_W-1:0] req);
    send_item(rand_item(req));
  endtask

  task automatic send_tick(logic [SEC_W-1:0] now_s, logic [SYNC_W-1:0] sync_s);
    step_req_t it;
    it = rand_item(REQ_TICK);
    it.now = now_s;
    it.sync = sync_s;
    send_item(it);
  endtask

  task automatic send_load(int idx, logic [OFF_W-1:0] off);
    step_req_t it;
    it = rand_item(REQ_LOAD);
    it.idx = IDX_W'(idx);
    it.off = off;
    send_item(it);
  endtask

  // Hold the input until every pending result is out, then let the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [CFG_D_W-1:0] start_v, logic [CFG_D_W-1:0] count_v);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_START_TIME;
    cfg_wdata <= start_v;
    @(posedge clk);
    sb.set_reg(CFG_START_TIME, start_v);
    cfg_addr <= CFG_STEP_COUNT;
    cfg_wdata <= count_v;
    @(posedge clk);
    sb.set_reg(CFG_STEP_COUNT, count_v);
    cfg_we <= 1'b0;
  endtask

  // One playback run: refresh the table, configure, sync, start, tick to the end, unless sync fails or a stop comes.
  task automatic play_run();
    int lim;
    int k;
    bit burst;
    logic [SEC_W-1:0] now_s;
    lim = (sb.step_count < STEP_DEPTH_DEF) ? sb.step_count : STEP_DEPTH_DEF;
    burst = ($urandom_range(0, 5) == 0);
    for (k = 0; k < lim; k++) begin
      if (burst) send_load(k, OFF_W'($urandom_range(0, TICK_MS - 1)));
      else if (sb.offsets[k] > 250) send_load(k, OFF_W'($urandom_range(0, 200)));
    end
    repeat ($urandom_range(0, 2)) send_load($urandom_range(0, STEP_DEPTH_DEF - 1),
                                           OFF_W'($urandom_range(0, 200)));
    send_cmd(REQ_CONFIG);
    repeat ($urandom_range(0, 2)) send_tick($urandom, $urandom_range(0, 1) ? SYNC_BUSY
                                                                          : SYNC_UNDEF);
    if ($urandom_range(0, 9) == 0) begin
      send_tick($urandom, SYNC_FAILED);
      return;
    end
    send_tick($urandom, SYNC_OK);
    send_cmd(REQ_START);
    if (sb.start_time != 0 && $urandom_range(0, 1))
      send_tick($urandom_range(0, 1) ? sb.start_time - 1 : $urandom % sb.start_time,
                SYNC_W'($urandom_range(0, 3)));
    now_s = sb.start_time + $urandom_range(0, 3);
    if (now_s < sb.start_time) now_s = '1;
    send_tick(now_s, SYNC_W'($urandom_range(0, 3)));
    for (k = 0; k < 40 && sb.mode == MODE_RUNNING; k++) begin
      if ($urandom_range(0, 24) == 0) begin
        send_cmd(REQ_STOP);
        send_tick($urandom, SYNC_W'($urandom_range(0, 3)));
        return;
      end
      if ($urandom_range(0, 9) == 0)
        send_item(rand_item(REQ_W'($urandom_range(0, REQ_RSVD_LAST))));
      send_tick($urandom, SYNC_W'($urandom_range(0, 3)));
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none near the end.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    tss_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.mode = mode_t'(out_tdata[2:0]);
      got.applied = out_tdata[3];
      got.vals = out_tdata[67:4];
      got.elapsed = out_tdata[99:68];
      got.sync_error = out_tdata[100];
      got.last = out_tlast;
      sb.check_result(got);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_timed_step_sequencer: FAIL");
    $finish;
  end

  initial begin : stimulus
    int k;
    int phase;
    step_req_t it;
    logic [CFG_D_W-1:0] start_v;
    logic [CFG_D_W-1:0] count_v;
    sb = new();
    rand_items = -1;
    calm = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_regs(32'd100, 32'd3);

    // fill the whole table; entries 0 and 1 are both due at tick zero
    for (k = 0; k < STEP_DEPTH_DEF; k++) begin
      it = rand_item(REQ_LOAD);
      it.idx = IDX_W'(k);
      it.off = OFF_W'(k * TICK_MS);
      if (k == 0) begin
        it.off = '0;
        {it.brk, it.imp, it.att, it.res} = {VALS_W{1'b0}};
      end else if (k == 1) begin
        it.off = OFF_W'(TICK_MS - 1);
        {it.brk, it.imp, it.att, it.res} = {VALS_W{1'b1}};
      end else if (k == STEP_DEPTH_DEF - 1) begin
        it.off = '1;
      end
      send_item(it);
    end

    for (k = REQ_RSVD_FIRST; k <= REQ_RSVD_LAST; k++) send_cmd(REQ_W'(k));
    send_tick('1, SYNC_OK);
    send_cmd(REQ_CONFIG);
    send_tick(32'd0, SYNC_BUSY);
    send_tick(32'd0, SYNC_UNDEF);
    send_tick(32'd0, SYNC_FAILED);
    send_cmd(REQ_CONFIG);
    send_tick('1, SYNC_OK);
    send_cmd(REQ_START);
    send_tick(32'd99, SYNC_OK);
    send_tick(32'd100, SYNC_BUSY);
    send_tick(32'd0, SYNC_FAILED);
    send_tick(32'd0, SYNC_OK);
    send_tick(32'd0, SYNC_OK);
    send_cmd(REQ_START);
    send_tick('1, SYNC_UNDEF);
    send_cmd(REQ_STOP);
    send_tick('1, SYNC_OK);
    send_cmd(REQ_CONFIG);

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      case (phase % 5)
        0: begin
          start_v = '0;
          count_v = CFG_D_W'(STEP_DEPTH_DEF);
        end
        1: begin
          start_v = '1;
          count_v = 32'd1;
        end
        2: begin
          start_v = $urandom;
          count_v = 32'd0;
        end
        3: begin
          start_v = $urandom;
          count_v = $urandom_range(STEP_DEPTH_DEF + 1, 31);
        end
        default: begin
          start_v = $urandom;
          count_v = $urandom_range(0, 1) ? $urandom : $urandom_range(1, STEP_DEPTH_DEF);
        end
      endcase
      write_regs(start_v, count_v);
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(2, 3)) begin
        if (rand_items >= RAND_ITEMS) break;
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4))
            send_item(rand_item(REQ_W'($urandom_range(0, REQ_RSVD_LAST))));
        else
          play_run();
      end
      phase++;
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_timed_step_sequencer: PASS");
    else
      $display("tb_timed_step_sequencer: FAIL");
    $finish;
  end

endmodule
